/* rtl/core/assert_macros.svh */
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// check on the rising edge of clk, off while rst is high
`define OBN_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check on the rising edge of clk, also active while rst is high
`define OBN_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

/* rtl/core/obn_pkg.sv */
// types and constants of the orthonormal basis pipeline
package obn_pkg;

  localparam int COORD_W   = 32;
  localparam int UNIT_W    = 32;
  localparam int FRAC_BITS = 30;
  localparam int MAG_W     = 32;
  localparam int SHIFT_W   = 5;
  localparam int SQ_W      = 64;
  localparam int ROOT_W    = 32;
  localparam int REM_W     = ROOT_W + 4;
  localparam int CUR_W     = MAG_W + 1;
  localparam int Q_W       = FRAC_BITS + 2;
  localparam int N_LANES   = 5;

  // divider lanes
  localparam int LANE_NX = 0;
  localparam int LANE_NY = 1;
  localparam int LANE_NZ = 2;
  localparam int LANE_MX = 3;
  localparam int LANE_MY = 4;

  localparam logic [UNIT_W-1:0] UNIT_ONE   = UNIT_W'(1) << FRAC_BITS;
  localparam logic [SQ_W-1:0]   ROUND_HALF = SQ_W'(1) << (FRAC_BITS - 1);

  typedef struct packed {
    logic signed [COORD_W-1:0] vec_x;
    logic signed [COORD_W-1:0] vec_y;
    logic signed [COORD_W-1:0] vec_z;
  } vec_t;

  typedef struct packed {
    logic signed [UNIT_W-1:0] unit_n_x;
    logic signed [UNIT_W-1:0] unit_n_y;
    logic signed [UNIT_W-1:0] unit_n_z;
    logic signed [UNIT_W-1:0] axis_m_x;
    logic signed [UNIT_W-1:0] axis_m_y;
    logic signed [UNIT_W-1:0] axis_m_z;
    logic signed [UNIT_W-1:0] axis_p_x;
    logic signed [UNIT_W-1:0] axis_p_y;
    logic signed [UNIT_W-1:0] axis_p_z;
    logic                     zero_vector_flag;
  } basis_t;

  // control bits that travel with each item
  typedef struct packed {
    logic valid;
    logic zero;
    logic neg_x;
    logic neg_y;
    logic neg_z;
    logic xy_zero;
  } tag_t;

  // one square root step, lane 0 for n and lane 1 for m
  typedef struct packed {
    tag_t                         tag;
    logic [2:0][MAG_W-1:0]        mag;
    logic [1:0][MAG_W-1:0]        mxy;
    logic [1:0][SQ_W-1:0]         rad;
    logic [1:0][REM_W-1:0]        rem;
    logic [1:0][ROOT_W-1:0]       root;
  } sqrt_stage_t;

  // one quotient bit step for all five lanes
  typedef struct packed {
    tag_t                         tag;
    logic [ROOT_W-1:0]            r_n;
    logic [ROOT_W-1:0]            r_m;
    logic [N_LANES-1:0][CUR_W-1:0] cur;
    logic [N_LANES-1:0][Q_W-1:0]   q;
  } div_stage_t;

endpackage

/* rtl/core/obn_sqrt_cell.sv */
// one restoring square root cell: one root bit for both radicands
module obn_sqrt_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  obn_pkg::sqrt_stage_t src,
  output obn_pkg::sqrt_stage_t dst
);

  obn_pkg::sqrt_stage_t                   nxt;
  logic [1:0][obn_pkg::REM_W-1:0]         shifted;
  logic [1:0][obn_pkg::REM_W-1:0]         trial;
  logic [1:0]                             ge;

  always_comb begin
    nxt = src;
    for (int i = 0; i < 2; i++) begin
      shifted[i] = {src.rem[i][obn_pkg::REM_W-3:0], src.rad[i][obn_pkg::SQ_W-1 -: 2]};
      trial[i]   = {{(obn_pkg::REM_W - obn_pkg::ROOT_W - 2){1'b0}}, src.root[i], 2'b01};
      ge[i]      = shifted[i] >= trial[i];
      nxt.rem[i] = ge[i] ? (shifted[i] - trial[i]) : shifted[i];
      nxt.root[i] = {src.root[i][obn_pkg::ROOT_W-2:0], ge[i]};
      nxt.rad[i]  = {src.rad[i][obn_pkg::SQ_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dst.tag.valid <= 1'b0;
    end else if (en) begin
      dst <= nxt;
    end
  end

endmodule

/* rtl/core/obn_div_cell.sv */
// one restoring divider cell: one quotient bit for each of the five lanes
module obn_div_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  obn_pkg::div_stage_t src,
  output obn_pkg::div_stage_t dst
);

  obn_pkg::div_stage_t                          nxt;
  logic [obn_pkg::N_LANES-1:0][obn_pkg::CUR_W-1:0] divisor;
  logic [obn_pkg::N_LANES-1:0][obn_pkg::CUR_W-1:0] rem;
  logic [obn_pkg::N_LANES-1:0]                     ge;

  always_comb begin
    nxt = src;
    for (int i = 0; i < obn_pkg::N_LANES; i++) begin
      // n lanes divide by the full length, m lanes by the xy length
      divisor[i] = (i < obn_pkg::LANE_MX) ? {1'b0, src.r_n} : {1'b0, src.r_m};
      ge[i]      = src.cur[i] >= divisor[i];
      rem[i]     = ge[i] ? (src.cur[i] - divisor[i]) : src.cur[i];
      nxt.cur[i] = {rem[i][obn_pkg::CUR_W-2:0], 1'b0};
      nxt.q[i]   = {src.q[i][obn_pkg::Q_W-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dst.tag.valid <= 1'b0;
    end else if (en) begin
      dst <= nxt;
    end
  end

endmodule

/* rtl/core/orthonormal_basis_from_normal_top.sv */
// top level of the orthonormal basis pipeline
// Takes one Q15.16 vector per transfer and returns n = v/|v|, m = (-y, x, 0)/|(x, y)|
// (or (1, 0, 0) when x and y are both zero) and p = n x m, all in Q1.30. A new vector
// can be taken on every cycle while vec_stall is low; results come out in order. The
// pipeline is five front stages (sign and magnitude, leading zero count, normalising
// shift, squares, sums), a row of 32 square root cells (one root bit each), a row of
// 32 divider cells (one quotient bit each, five lanes side by side), three stages for
// the cross product and the output register. A zero input vector gives all zeros
// with zero_vector_flag set. A one-entry skid register behind the output register
// keeps the pipeline moving for one extra transfer while the output is stalled;
// vec_stall rises only once that register is full.
`include "assert_macros.svh"

module orthonormal_basis_from_normal_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            vec_valid,
  output logic            vec_stall,
  input  obn_pkg::vec_t   vec,
  output logic            basis_valid,
  input  logic            basis_stall,
  output obn_pkg::basis_t basis
);

  // shift that brings the top set bit to bit 30 (none when bit 31 is set)
  function automatic logic [obn_pkg::SHIFT_W-1:0] norm_shift(
    input logic [obn_pkg::MAG_W-1:0] x
  );
    logic [obn_pkg::MAG_W-1:0]   v;
    logic [obn_pkg::SHIFT_W-1:0] n;
    begin
      v = x;
      n = '0;
      if (v[31:16] == '0) begin
        n = n + obn_pkg::SHIFT_W'(16);
        v = v << 16;
      end
      if (v[31:24] == '0) begin
        n = n + obn_pkg::SHIFT_W'(8);
        v = v << 8;
      end
      if (v[31:28] == '0) begin
        n = n + obn_pkg::SHIFT_W'(4);
        v = v << 4;
      end
      if (v[31:30] == '0) begin
        n = n + obn_pkg::SHIFT_W'(2);
        v = v << 2;
      end
      if (v[31] == 1'b0) begin
        n = n + obn_pkg::SHIFT_W'(1);
      end
      norm_shift = (n == '0) ? '0 : n - obn_pkg::SHIFT_W'(1);
    end
  endfunction

  // two's complement of a magnitude when the sign is set
  function automatic logic [obn_pkg::UNIT_W-1:0] apply_sign(
    input logic                      s,
    input logic [obn_pkg::UNIT_W-1:0] m
  );
    begin
      apply_sign = s ? (~m + 1'b1) : m;
    end
  endfunction

  // whole pipeline moves unless the skid register holds a result
  logic en;
  logic skid_v;
  obn_pkg::basis_t skid;

  assign en        = !skid_v;
  assign vec_stall = skid_v;

  // stage 0: sign and magnitude
  logic [2:0][obn_pkg::COORD_W-1:0] in_raw;
  logic [2:0][obn_pkg::MAG_W-1:0]   in_mag;
  obn_pkg::tag_t                    in_tag;

  assign in_raw = {vec.vec_z, vec.vec_y, vec.vec_x};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_mag[i] = in_raw[i][obn_pkg::COORD_W-1] ? (~in_raw[i] + 1'b1) : in_raw[i];
    end
    in_tag.valid   = vec_valid;
    in_tag.zero    = (in_raw == '0);
    in_tag.neg_x   = in_raw[0][obn_pkg::COORD_W-1];
    in_tag.neg_y   = in_raw[1][obn_pkg::COORD_W-1];
    in_tag.neg_z   = in_raw[2][obn_pkg::COORD_W-1];
    in_tag.xy_zero = (in_raw[0] == '0) && (in_raw[1] == '0);
  end

  obn_pkg::tag_t                  s0_tag;
  logic [2:0][obn_pkg::MAG_W-1:0] s0_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_tag.valid <= 1'b0;
    end else if (en) begin
      s0_tag <= in_tag;
      s0_mag <= in_mag;
    end
  end

  // stage 1: common shifts for the full vector and for the xy pair
  obn_pkg::tag_t                  s1_tag;
  logic [2:0][obn_pkg::MAG_W-1:0] s1_mag;
  logic [obn_pkg::SHIFT_W-1:0]    s1_sh_n;
  logic [obn_pkg::SHIFT_W-1:0]    s1_sh_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_tag.valid <= 1'b0;
    end else if (en) begin
      s1_tag  <= s0_tag;
      s1_mag  <= s0_mag;
      s1_sh_n <= norm_shift(s0_mag[0] | s0_mag[1] | s0_mag[2]);
      s1_sh_m <= norm_shift(s0_mag[0] | s0_mag[1]);
    end
  end

  // stage 2: normalised magnitudes
  obn_pkg::tag_t                  s2_tag;
  logic [2:0][obn_pkg::MAG_W-1:0] s2_a;
  logic [1:0][obn_pkg::MAG_W-1:0] s2_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_tag.valid <= 1'b0;
    end else if (en) begin
      s2_tag <= s1_tag;
      for (int i = 0; i < 3; i++) begin
        s2_a[i] <= s1_mag[i] << s1_sh_n;
      end
      for (int i = 0; i < 2; i++) begin
        s2_b[i] <= s1_mag[i] << s1_sh_m;
      end
    end
  end

  // stage 3: squares
  obn_pkg::tag_t                  s3_tag;
  logic [2:0][obn_pkg::MAG_W-1:0] s3_a;
  logic [1:0][obn_pkg::MAG_W-1:0] s3_b;
  logic [2:0][obn_pkg::SQ_W-1:0]  s3_sq;
  logic [1:0][obn_pkg::SQ_W-1:0]  s3_sqm;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_tag.valid <= 1'b0;
    end else if (en) begin
      s3_tag <= s2_tag;
      s3_a   <= s2_a;
      s3_b   <= s2_b;
      for (int i = 0; i < 3; i++) begin
        s3_sq[i] <= obn_pkg::SQ_W'(s2_a[i]) * obn_pkg::SQ_W'(s2_a[i]);
      end
      for (int i = 0; i < 2; i++) begin
        s3_sqm[i] <= obn_pkg::SQ_W'(s2_b[i]) * obn_pkg::SQ_W'(s2_b[i]);
      end
    end
  end

  // stage 4: sums of squares
  obn_pkg::tag_t                  s4_tag;
  logic [2:0][obn_pkg::MAG_W-1:0] s4_a;
  logic [1:0][obn_pkg::MAG_W-1:0] s4_b;
  logic [obn_pkg::SQ_W-1:0]       s4_sn;
  logic [obn_pkg::SQ_W-1:0]       s4_sm;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_tag.valid <= 1'b0;
    end else if (en) begin
      s4_tag <= s3_tag;
      s4_a   <= s3_a;
      s4_b   <= s3_b;
      s4_sn  <= s3_sq[0] + s3_sq[1] + s3_sq[2];
      s4_sm  <= s3_sqm[0] + s3_sqm[1];
    end
  end

  // square root row
  obn_pkg::sqrt_stage_t sq_chain [obn_pkg::ROOT_W+1];
  obn_pkg::sqrt_stage_t sq_init;

  always_comb begin
    sq_init.tag    = s4_tag;
    sq_init.mag    = s4_a;
    sq_init.mxy    = s4_b;
    sq_init.rad[0] = s4_sn;
    sq_init.rad[1] = s4_sm;
    sq_init.rem    = '0;
    sq_init.root   = '0;
  end

  assign sq_chain[0] = sq_init;

  for (genvar k = 0; k < obn_pkg::ROOT_W; k++) begin : g_sqrt
    obn_sqrt_cell u_cell (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .src (sq_chain[k]),
      .dst (sq_chain[k+1])
    );
  end

  // divider row: each lane gives mag * 2^30 / r, truncated, plus one guard bit
  obn_pkg::div_stage_t dv_chain [obn_pkg::Q_W+1];
  obn_pkg::div_stage_t dv_init;
  obn_pkg::sqrt_stage_t sq_last;

  assign sq_last = sq_chain[obn_pkg::ROOT_W];

  always_comb begin
    dv_init.tag = sq_last.tag;
    dv_init.r_n = sq_last.root[0];
    dv_init.r_m = sq_last.root[1];
    dv_init.cur[obn_pkg::LANE_NX] = {1'b0, sq_last.mag[0]};
    dv_init.cur[obn_pkg::LANE_NY] = {1'b0, sq_last.mag[1]};
    dv_init.cur[obn_pkg::LANE_NZ] = {1'b0, sq_last.mag[2]};
    dv_init.cur[obn_pkg::LANE_MX] = {1'b0, sq_last.mxy[1]};
    dv_init.cur[obn_pkg::LANE_MY] = {1'b0, sq_last.mxy[0]};
    dv_init.q = '0;
  end

  assign dv_chain[0] = dv_init;

  for (genvar k = 0; k < obn_pkg::Q_W; k++) begin : g_div
    obn_div_cell u_cell (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .src (dv_chain[k]),
      .dst (dv_chain[k+1])
    );
  end

  // c1: rounded magnitudes and signs, fallback axis when x and y are zero
  obn_pkg::div_stage_t                           dv_last;
  logic [obn_pkg::N_LANES-1:0][obn_pkg::Q_W-1:0] qr;
  obn_pkg::tag_t                                 c1_tag;
  logic [obn_pkg::N_LANES-1:0][obn_pkg::Q_W-1:0] c1_mag;
  logic [obn_pkg::N_LANES-1:0]                   c1_sgn;

  assign dv_last = dv_chain[obn_pkg::Q_W];

  always_comb begin
    for (int i = 0; i < obn_pkg::N_LANES; i++) begin
      // drop the guard bit and round half up with it
      qr[i] = {1'b0, dv_last.q[i][obn_pkg::Q_W-1:1]} + obn_pkg::Q_W'(dv_last.q[i][0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_tag.valid <= 1'b0;
    end else if (en) begin
      c1_tag <= dv_last.tag;
      c1_mag[obn_pkg::LANE_NX] <= qr[obn_pkg::LANE_NX];
      c1_mag[obn_pkg::LANE_NY] <= qr[obn_pkg::LANE_NY];
      c1_mag[obn_pkg::LANE_NZ] <= qr[obn_pkg::LANE_NZ];
      c1_sgn[obn_pkg::LANE_NX] <= dv_last.tag.neg_x;
      c1_sgn[obn_pkg::LANE_NY] <= dv_last.tag.neg_y;
      c1_sgn[obn_pkg::LANE_NZ] <= dv_last.tag.neg_z;
      if (dv_last.tag.xy_zero) begin
        c1_mag[obn_pkg::LANE_MX] <= obn_pkg::UNIT_ONE;
        c1_mag[obn_pkg::LANE_MY] <= '0;
        c1_sgn[obn_pkg::LANE_MX] <= 1'b0;
        c1_sgn[obn_pkg::LANE_MY] <= 1'b0;
      end else begin
        c1_mag[obn_pkg::LANE_MX] <= qr[obn_pkg::LANE_MX];
        c1_mag[obn_pkg::LANE_MY] <= qr[obn_pkg::LANE_MY];
        c1_sgn[obn_pkg::LANE_MX] <= !dv_last.tag.neg_y;
        c1_sgn[obn_pkg::LANE_MY] <= dv_last.tag.neg_x;
      end
    end
  end

  // c2: signed n and m, cross product partial magnitudes
  // products: nz*my, nz*mx, nx*my, ny*mx
  obn_pkg::tag_t                      c2_tag;
  logic [obn_pkg::N_LANES-1:0][obn_pkg::UNIT_W-1:0] c2_val;
  logic [3:0][obn_pkg::SQ_W-1:0]      c2_prod;
  logic [3:0]                         c2_psgn;

  always_ff @(posedge clk) begin
    if (rst) begin
      c2_tag.valid <= 1'b0;
    end else if (en) begin
      c2_tag <= c1_tag;
      for (int i = 0; i < obn_pkg::N_LANES; i++) begin
        c2_val[i] <= apply_sign(c1_sgn[i], c1_mag[i]);
      end
      c2_prod[0] <= obn_pkg::SQ_W'(c1_mag[obn_pkg::LANE_NZ])
                  * obn_pkg::SQ_W'(c1_mag[obn_pkg::LANE_MY]);
      c2_prod[1] <= obn_pkg::SQ_W'(c1_mag[obn_pkg::LANE_NZ])
                  * obn_pkg::SQ_W'(c1_mag[obn_pkg::LANE_MX]);
      c2_prod[2] <= obn_pkg::SQ_W'(c1_mag[obn_pkg::LANE_NX])
                  * obn_pkg::SQ_W'(c1_mag[obn_pkg::LANE_MY]);
      c2_prod[3] <= obn_pkg::SQ_W'(c1_mag[obn_pkg::LANE_NY])
                  * obn_pkg::SQ_W'(c1_mag[obn_pkg::LANE_MX]);
      c2_psgn[0] <= c1_sgn[obn_pkg::LANE_NZ] ^ c1_sgn[obn_pkg::LANE_MY];
      c2_psgn[1] <= c1_sgn[obn_pkg::LANE_NZ] ^ c1_sgn[obn_pkg::LANE_MX];
      c2_psgn[2] <= c1_sgn[obn_pkg::LANE_NX] ^ c1_sgn[obn_pkg::LANE_MY];
      c2_psgn[3] <= c1_sgn[obn_pkg::LANE_NY] ^ c1_sgn[obn_pkg::LANE_MX];
    end
  end

  // c3: round the products, form p, saturate p_z, zero vector override
  logic [3:0][obn_pkg::SQ_W-1:0]     rnd;
  logic [3:0][obn_pkg::UNIT_W-1:0]   rmag;
  logic [obn_pkg::UNIT_W-1:0]        p_x;
  logic [obn_pkg::UNIT_W-1:0]        p_y;
  logic [obn_pkg::UNIT_W-1:0]        p_z;
  logic [obn_pkg::UNIT_W-1:0]        term_a;
  logic [obn_pkg::UNIT_W-1:0]        term_b;
  logic signed [obn_pkg::UNIT_W+1:0] diff;
  logic signed [obn_pkg::UNIT_W+1:0] one_w;
  obn_pkg::basis_t                   c3_next;
  obn_pkg::basis_t                   c3_data;
  logic                              c3_v;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rnd[i]  = c2_prod[i] + obn_pkg::ROUND_HALF;
      rmag[i] = rnd[i][obn_pkg::FRAC_BITS +: obn_pkg::UNIT_W];
    end
    p_x    = apply_sign(!c2_psgn[0], rmag[0]);
    p_y    = apply_sign(c2_psgn[1], rmag[1]);
    term_a = apply_sign(c2_psgn[2], rmag[2]);
    term_b = apply_sign(c2_psgn[3], rmag[3]);
    diff   = $signed({{2{term_a[obn_pkg::UNIT_W-1]}}, term_a})
           - $signed({{2{term_b[obn_pkg::UNIT_W-1]}}, term_b});
    one_w  = $signed({2'b00, obn_pkg::UNIT_ONE});
    if (diff > one_w) begin
      p_z = obn_pkg::UNIT_ONE;
    end else if (diff < -one_w) begin
      p_z = ~obn_pkg::UNIT_ONE + 1'b1;
    end else begin
      p_z = diff[obn_pkg::UNIT_W-1:0];
    end

    if (c2_tag.zero) begin
      c3_next                  = '0;
      c3_next.zero_vector_flag = 1'b1;
    end else begin
      c3_next.unit_n_x         = c2_val[obn_pkg::LANE_NX];
      c3_next.unit_n_y         = c2_val[obn_pkg::LANE_NY];
      c3_next.unit_n_z         = c2_val[obn_pkg::LANE_NZ];
      c3_next.axis_m_x         = c2_val[obn_pkg::LANE_MX];
      c3_next.axis_m_y         = c2_val[obn_pkg::LANE_MY];
      c3_next.axis_m_z         = '0;
      c3_next.axis_p_x         = p_x;
      c3_next.axis_p_y         = p_y;
      c3_next.axis_p_z         = p_z;
      c3_next.zero_vector_flag = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c3_v <= 1'b0;
    end else if (en) begin
      c3_v    <= c2_tag.valid;
      c3_data <= c3_next;
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      basis_valid <= 1'b0;
      skid_v      <= 1'b0;
    end else if (!basis_valid || !basis_stall) begin
      if (skid_v) begin
        basis_valid <= 1'b1;
        skid_v      <= 1'b0;
      end else begin
        basis_valid <= c3_v;
      end
    end else if (c3_v) begin
      // output held, the last stage drains into the skid entry
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!basis_valid || !basis_stall) begin
      basis <= skid_v ? skid : c3_data;
    end else if (c3_v && !skid_v) begin
      skid <= c3_data;
    end
  end

  // checks
  `OBN_ASSERT_ALWAYS(a_reset_empties, rst |=> !basis_valid && !skid_v, "reset left a result")
  `OBN_ASSERT(a_skid_behind_out, skid_v |-> basis_valid, "skid entry without output")
  `OBN_ASSERT(a_skid_fill, $rose(skid_v) |-> $past(basis_valid && basis_stall), "bad skid fill")
  `OBN_ASSERT(a_zero_result,
              basis_valid && basis.zero_vector_flag |-> basis.unit_n_x == '0
              && basis.unit_n_z == '0 && basis.axis_m_x == '0 && basis.axis_p_z == '0,
              "zero vector result not cleared")

endmodule
